FILE: src/ecs_pkg.sv
// ----------------------------------------------------------------------------
// ecs_pkg: shared types and constants for the eight-op CPU step unit
// Beat structs, opcode and ALU operation codes, instruction field positions.
// ----------------------------------------------------------------------------
package ecs_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned OPC_W    = 3;
  localparam int unsigned OPC_LSB  = 22;
  localparam int unsigned REGA_LSB = 19;
  localparam int unsigned REGB_LSB = 16;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned NUM_REGS = 8;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_e;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_NOR = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic                     kind;
    logic [ADDR_W-1:0]        load_address;
    logic signed [WORD_W-1:0] load_data;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]        pc_now;
    logic                     halted;
    logic [OPC_W-1:0]         opcode_done;
    logic                     reg_write;
    logic [REG_IDX_W-1:0]     reg_index;
    logic signed [WORD_W-1:0] reg_value;
    logic                     mem_write;
    logic [ADDR_W-1:0]        mem_address;
    logic signed [WORD_W-1:0] mem_value;
    logic [WORD_W-1:0]        executed_count;
  } out_t;

endpackage

FILE: src/ecs_ram.sv
// ----------------------------------------------------------------------------
// ecs_ram: generic single-port RAM
// One access per cycle, write or read; read data registered.
// ----------------------------------------------------------------------------
module ecs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ecs_regfile.sv
// ----------------------------------------------------------------------------
// ecs_regfile: eight-entry general register file
// One read port, one write port; all registers clear on reset.
// ----------------------------------------------------------------------------
module ecs_regfile (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [ecs_pkg::REG_IDX_W-1:0]    waddr_i,
  input  logic [ecs_pkg::WORD_W-1:0]       wdata_i,
  input  logic [ecs_pkg::REG_IDX_W-1:0]    raddr_i,
  output logic [ecs_pkg::WORD_W-1:0]       rdata_o
);

  logic [ecs_pkg::WORD_W-1:0] regs_q [ecs_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ecs_pkg::NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else if (we_i) begin
      regs_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = regs_q[raddr_i];

endmodule

FILE: src/ecs_alu.sv
// ----------------------------------------------------------------------------
// ecs_alu: shared arithmetic unit
// 32-bit add or nor, plus an equality flag on the same operands.
// ----------------------------------------------------------------------------
module ecs_alu (
  input  ecs_pkg::alu_op_e           op_i,
  input  logic [ecs_pkg::WORD_W-1:0] x_i,
  input  logic [ecs_pkg::WORD_W-1:0] y_i,
  output logic [ecs_pkg::WORD_W-1:0] res_o,
  output logic                       eq_o
);

  always_comb begin
    unique case (op_i)
      ecs_pkg::ALU_ADD: res_o = x_i + y_i;
      ecs_pkg::ALU_NOR: res_o = ~(x_i | y_i);
      default:          res_o = x_i + y_i;
    endcase
  end

  assign eq_o = (x_i == y_i);

endmodule

FILE: src/eight_op_cpu_step_unit.sv
// ----------------------------------------------------------------------------
// eight_op_cpu_step_unit: multicycle eight-opcode 32-bit processor step unit
// Load beats write one memory word; step beats run one instruction through a
// small sequencer around one ALU, one register file port and one memory port.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (ecs_pkg::in_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (ecs_pkg::out_t)
//
// Cycles per beat: load or step after halt 2, lw 6, other steps 5; the single
// memory port and the single register read port set the step length.
// MEM_WORDS must be a power of two; addresses and pc wrap on its low bits.
// Reset clears registers, pc, halt flag and count; memory is not cleared.
// A held result sits in the output register; the next beat is accepted
// meanwhile and waits at its last state only if the output is still stalled.
// ----------------------------------------------------------------------------
module eight_op_cpu_step_unit #(
  parameter int unsigned MEM_WORDS = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ecs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ecs_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FETCH = 6'b000010,
    ST_REGB  = 6'b000100,
    ST_EXEC  = 6'b001000,
    ST_MEM   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  logic [AW-1:0]              pc_q, pc_d;
  logic                       halted_q, halted_d;
  logic [ecs_pkg::WORD_W-1:0] count_q, count_d;
  logic [ecs_pkg::WORD_W-1:0] ir_q, ir_d;
  logic [ecs_pkg::WORD_W-1:0] a_q, a_d;
  logic [ecs_pkg::WORD_W-1:0] b_q, b_d;
  logic                       eq_q, eq_d;
  ecs_pkg::out_t              res_q, res_d;
  ecs_pkg::out_t              out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic                       ram_en, ram_we;
  logic [AW-1:0]              ram_addr;
  logic [ecs_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  logic                              rf_we;
  logic [ecs_pkg::REG_IDX_W-1:0]     rf_waddr, rf_raddr;
  logic [ecs_pkg::WORD_W-1:0]        rf_wdata, rf_rdata;

  ecs_pkg::alu_op_e           alu_op;
  logic [ecs_pkg::WORD_W-1:0] alu_x, alu_y, alu_res;
  logic                       alu_eq;

  ecs_pkg::opcode_e              opcode;
  logic [ecs_pkg::REG_IDX_W-1:0] idx_a, idx_b, idx_d;
  logic [ecs_pkg::WORD_W-1:0]    off_ext;
  logic [AW:0]                   pc_inc;

  assign opcode  = ecs_pkg::opcode_e'(ir_q[ecs_pkg::OPC_LSB +: ecs_pkg::OPC_W]);
  assign idx_a   = ir_q[ecs_pkg::REGA_LSB +: ecs_pkg::REG_IDX_W];
  assign idx_b   = ir_q[ecs_pkg::REGB_LSB +: ecs_pkg::REG_IDX_W];
  assign idx_d   = ir_q[ecs_pkg::REG_IDX_W-1:0];
  assign off_ext = {{(ecs_pkg::WORD_W-ecs_pkg::OFF_W){ir_q[ecs_pkg::OFF_W-1]}},
                    ir_q[ecs_pkg::OFF_W-1:0]};
  assign pc_inc  = {1'b0, pc_q} + (AW+1)'(1);

  ecs_ram #(
    .WIDTH (ecs_pkg::WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  ecs_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  ecs_alu u_alu (
    .op_i  (alu_op),
    .x_i   (alu_x),
    .y_i   (alu_y),
    .res_o (alu_res),
    .eq_o  (alu_eq)
  );

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    halted_d    = halted_q;
    count_d     = count_q;
    ir_d        = ir_q;
    a_d         = a_q;
    b_d         = b_q;
    eq_d        = eq_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = pc_q;
    ram_wdata = in_data_i.load_data;
    rf_we     = 1'b0;
    rf_waddr  = idx_d;
    rf_wdata  = alu_res;
    rf_raddr  = idx_b;
    alu_op    = ecs_pkg::ALU_ADD;
    alu_x     = a_q;
    alu_y     = b_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d                = '0;
          res_d.pc_now         = ecs_pkg::ADDR_W'(pc_q);
          res_d.halted         = halted_q;
          res_d.executed_count = count_q;
          if (in_data_i.kind == ecs_pkg::KIND_LOAD) begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = in_data_i.load_address[AW-1:0];
            state_d  = ST_DONE;
          end else if (halted_q) begin
            state_d = ST_DONE;
          end else begin
            ram_en   = 1'b1;
            ram_addr = pc_q;
            state_d  = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        ir_d     = ram_rdata;
        rf_raddr = ram_rdata[ecs_pkg::REGA_LSB +: ecs_pkg::REG_IDX_W];
        a_d      = rf_rdata;
        state_d  = ST_REGB;
      end
      ST_REGB: begin
        rf_raddr = idx_b;
        b_d      = rf_rdata;
        alu_x    = a_q;
        alu_y    = rf_rdata;
        eq_d     = alu_eq;
        state_d  = ST_EXEC;
      end
      ST_EXEC: begin
        count_d = (count_q != '1) ? count_q + 32'd1 : count_q;
        pc_d    = pc_inc[AW-1:0];
        res_d   = '0;
        res_d.opcode_done = opcode;
        state_d = ST_DONE;
        unique case (opcode)
          ecs_pkg::OP_ADD, ecs_pkg::OP_NOR: begin
            alu_op          = (opcode == ecs_pkg::OP_NOR) ? ecs_pkg::ALU_NOR
                                                         : ecs_pkg::ALU_ADD;
            rf_we           = 1'b1;
            rf_waddr        = idx_d;
            rf_wdata        = alu_res;
            res_d.reg_write = 1'b1;
            res_d.reg_index = idx_d;
            res_d.reg_value = alu_res;
          end
          ecs_pkg::OP_LW: begin
            alu_y    = off_ext;
            ram_en   = 1'b1;
            ram_addr = alu_res[AW-1:0];
            state_d  = ST_MEM;
          end
          ecs_pkg::OP_SW: begin
            alu_y             = off_ext;
            ram_en            = 1'b1;
            ram_we            = 1'b1;
            ram_addr          = alu_res[AW-1:0];
            ram_wdata         = b_q;
            res_d.mem_write   = 1'b1;
            res_d.mem_address = ecs_pkg::ADDR_W'(alu_res[AW-1:0]);
            res_d.mem_value   = b_q;
          end
          ecs_pkg::OP_BEQ: begin
            alu_x = ecs_pkg::WORD_W'(pc_inc);
            alu_y = off_ext;
            if (eq_q) begin
              pc_d = alu_res[AW-1:0];
            end
          end
          ecs_pkg::OP_JALR: begin
            rf_we           = 1'b1;
            rf_waddr        = idx_b;
            rf_wdata        = ecs_pkg::WORD_W'(pc_inc);
            res_d.reg_write = 1'b1;
            res_d.reg_index = idx_b;
            res_d.reg_value = ecs_pkg::WORD_W'(pc_inc);
            // target is rA read after the link write
            pc_d = (idx_a == idx_b) ? pc_inc[AW-1:0] : a_q[AW-1:0];
          end
          ecs_pkg::OP_HALT: begin
            halted_d = 1'b1;
          end
          ecs_pkg::OP_NOOP: begin
          end
        endcase
        res_d.pc_now         = ecs_pkg::ADDR_W'(pc_d);
        res_d.halted         = halted_d;
        res_d.executed_count = count_d;
      end
      ST_MEM: begin
        rf_we                = 1'b1;
        rf_waddr             = idx_b;
        rf_wdata             = ram_rdata;
        res_d                = '0;
        res_d.pc_now         = ecs_pkg::ADDR_W'(pc_q);
        res_d.halted         = halted_q;
        res_d.executed_count = count_q;
        res_d.opcode_done    = ecs_pkg::OP_LW;
        res_d.reg_write      = 1'b1;
        res_d.reg_index      = idx_b;
        res_d.reg_value      = ram_rdata;
        state_d              = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      halted_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      halted_q    <= halted_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q  <= ir_d;
    a_q   <= a_d;
    b_q   <= b_d;
    eq_q  <= eq_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/ecs_checker.sv
// ----------------------------------------------------------------------------
// ecs_checker: port-level checks for the eight-op CPU step unit
// Output beat hold, busy after accept, sticky halt, reg and mem write opcodes.
// ----------------------------------------------------------------------------
module ecs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input ecs_pkg::out_t out_data_o
);

  logic seen_halt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (out_valid_o && out_data_o.halted) begin
      seen_halt_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted again before the beat finished");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_halt_q |-> out_data_o.halted)
    else $error("halted flag cleared after a halt");

  a_reg_write_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.reg_write |->
      out_data_o.opcode_done == ecs_pkg::OP_ADD ||
      out_data_o.opcode_done == ecs_pkg::OP_NOR ||
      out_data_o.opcode_done == ecs_pkg::OP_LW  ||
      out_data_o.opcode_done == ecs_pkg::OP_JALR)
    else $error("register write reported for an opcode that writes none");

  a_mem_write_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mem_write |->
      out_data_o.opcode_done == ecs_pkg::OP_SW && !out_data_o.reg_write)
    else $error("memory write reported without a store");

endmodule

bind eight_op_cpu_step_unit ecs_checker u_ecs_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the eight-op CPU step unit
// Small programs are loaded word by word and stepped through the core. A
// shadow core plans each program so that no fetch or lw touches an unwritten
// word. A second shadow core runs each accepted input beat and predicts the
// result beat, which is checked field by field. Sender and receiver idle at
// several rates. One long output hold-off fills the core. The run ends with a
// halt and a few beats after it.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MEM_WORDS    = 65536;
  localparam int          PLAN_CORE    = 0;
  localparam int          CHECK_CORE   = 1;
  localparam int unsigned PHASE_BEATS  = 125;
  localparam int unsigned HOLD_BEATS   = 40;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic          clk;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  ecs_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  ecs_pkg::out_t out_data;

  // two shadow cores: one plans programs, one predicts accepted beats
  bit [ecs_pkg::WORD_W-1:0] core_mem     [2][MEM_WORDS];
  bit                       core_written [2][MEM_WORDS];
  bit [ecs_pkg::WORD_W-1:0] core_regs    [2][ecs_pkg::NUM_REGS];
  bit [ecs_pkg::ADDR_W-1:0] core_pc      [2];
  bit                       core_halted  [2];
  bit [ecs_pkg::WORD_W-1:0] core_retired [2];

  ecs_pkg::in_t             program_beats[$];
  ecs_pkg::out_t            predicted_effects[$];
  bit [ecs_pkg::ADDR_W-1:0] written_addrs[$];

  int unsigned beats_queued     = 0;
  int unsigned effects_seen     = 0;
  int unsigned effect_mismatches = 0;
  int unsigned send_idle_pct    = 0;
  int unsigned recv_stall_pct   = 0;
  int unsigned hold_requests    = 0;
  int unsigned holds_seen       = 0;
  int unsigned hold_left        = 0;
  int unsigned cycles           = 0;

  eight_op_cpu_step_unit #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  function automatic bit [ecs_pkg::ADDR_W-1:0] wrap_addr(
      input bit [ecs_pkg::WORD_W-1:0] a);
    return ecs_pkg::ADDR_W'(a % MEM_WORDS);
  endfunction

  function automatic bit [ecs_pkg::WORD_W-1:0] sext_off(
      input bit [ecs_pkg::WORD_W-1:0] w);
    return {{(ecs_pkg::WORD_W-ecs_pkg::OFF_W){w[ecs_pkg::OFF_W-1]}},
            w[ecs_pkg::OFF_W-1:0]};
  endfunction

  function automatic ecs_pkg::out_t run_cpu_beat(input int c, input ecs_pkg::in_t beat);
    ecs_pkg::out_t            r;
    bit [ecs_pkg::WORD_W-1:0] word;
    bit [ecs_pkg::WORD_W-1:0] off;
    bit [ecs_pkg::WORD_W-1:0] va;
    bit [ecs_pkg::WORD_W-1:0] vb;
    bit [2:0]                 ra;
    bit [2:0]                 rb;
    bit [ecs_pkg::ADDR_W-1:0] pc;
    bit [ecs_pkg::ADDR_W-1:0] nxt;
    bit [ecs_pkg::ADDR_W-1:0] ea;
    ecs_pkg::opcode_e         op;
    r = '0;
    if (beat.kind == ecs_pkg::KIND_LOAD) begin
      core_mem[c][beat.load_address]     = beat.load_data;
      core_written[c][beat.load_address] = 1'b1;
    end else if (!core_halted[c]) begin
      pc   = core_pc[c];
      word = core_mem[c][pc];
      ra   = word[ecs_pkg::REGA_LSB +: ecs_pkg::REG_IDX_W];
      rb   = word[ecs_pkg::REGB_LSB +: ecs_pkg::REG_IDX_W];
      off  = sext_off(word);
      va   = core_regs[c][ra];
      vb   = core_regs[c][rb];
      nxt  = wrap_addr({16'd0, pc} + 32'd1);
      op   = ecs_pkg::opcode_e'(word[ecs_pkg::OPC_LSB +: ecs_pkg::OPC_W]);
      r.opcode_done = op;
      case (op)
        ecs_pkg::OP_ADD: begin
          r.reg_write = 1'b1;
          r.reg_index = word[2:0];
          r.reg_value = va + vb;
        end
        ecs_pkg::OP_NOR: begin
          r.reg_write = 1'b1;
          r.reg_index = word[2:0];
          r.reg_value = ~(va | vb);
        end
        ecs_pkg::OP_LW: begin
          r.reg_write = 1'b1;
          r.reg_index = rb;
          r.reg_value = core_mem[c][wrap_addr(va + off)];
        end
        ecs_pkg::OP_SW: begin
          ea = wrap_addr(va + off);
          r.mem_write   = 1'b1;
          r.mem_address = ea;
          r.mem_value   = vb;
          core_mem[c][ea]     = vb;
          core_written[c][ea] = 1'b1;
        end
        ecs_pkg::OP_BEQ: begin
          if (va == vb) nxt = wrap_addr({16'd0, pc} + 32'd1 + off);
        end
        ecs_pkg::OP_JALR: begin
          r.reg_write = 1'b1;
          r.reg_index = rb;
          r.reg_value = {16'd0, pc} + 32'd1;
        end
        ecs_pkg::OP_HALT: core_halted[c] = 1'b1;
        default: ;
      endcase
      if (r.reg_write) core_regs[c][r.reg_index] = r.reg_value;
      // jalr target is read after the link write
      if (op == ecs_pkg::OP_JALR) nxt = wrap_addr(core_regs[c][ra]);
      core_pc[c] = nxt;
      if (core_retired[c] != '1) core_retired[c] = core_retired[c] + 1;
    end
    r.pc_now         = core_pc[c];
    r.halted         = core_halted[c];
    r.executed_count = core_retired[c];
    return r;
  endfunction

  function automatic string show_result(input ecs_pkg::out_t r);
    return $sformatf("pc=%h halt=%b op=%0d rw=%b ri=%0d rv=%h mw=%b ma=%h mv=%h cnt=%0d",
                     r.pc_now, r.halted, r.opcode_done, r.reg_write, r.reg_index,
                     r.reg_value, r.mem_write, r.mem_address, r.mem_value,
                     r.executed_count);
  endfunction

  function automatic bit [ecs_pkg::WORD_W-1:0] encode(input ecs_pkg::opcode_e op,
                                                      input bit [2:0] ra,
                                                      input bit [2:0] rb,
                                                      input bit [15:0] low);
    return {7'd0, op, ra, rb, low};
  endfunction

  function automatic ecs_pkg::in_t load_item(input bit [ecs_pkg::ADDR_W-1:0] addr,
                                             input bit [ecs_pkg::WORD_W-1:0] data);
    ecs_pkg::in_t b;
    b.kind         = ecs_pkg::KIND_LOAD;
    b.load_address = addr;
    b.load_data    = data;
    return b;
  endfunction

  function automatic ecs_pkg::in_t step_item();
    ecs_pkg::in_t b;
    b.kind         = ecs_pkg::KIND_STEP;
    b.load_address = ecs_pkg::ADDR_W'($urandom);
    b.load_data    = $urandom;
    return b;
  endfunction

  // true when the word at pc may be stepped as it stands
  function automatic bit fetch_ok(input bit [ecs_pkg::ADDR_W-1:0] pc);
    bit [ecs_pkg::WORD_W-1:0] w;
    bit [ecs_pkg::WORD_W-1:0] ea;
    ecs_pkg::opcode_e         op;
    w  = core_mem[PLAN_CORE][pc];
    op = ecs_pkg::opcode_e'(w[ecs_pkg::OPC_LSB +: ecs_pkg::OPC_W]);
    if (!core_written[PLAN_CORE][pc] || op == ecs_pkg::OP_HALT) return 1'b0;
    if (op == ecs_pkg::OP_LW) begin
      ea = core_regs[PLAN_CORE][w[ecs_pkg::REGA_LSB +: ecs_pkg::REG_IDX_W]]
         + sext_off(w);
      return core_written[PLAN_CORE][wrap_addr(ea)];
    end
    return 1'b1;
  endfunction

  function automatic bit [ecs_pkg::WORD_W-1:0] make_instr();
    bit [ecs_pkg::WORD_W-1:0] w;
    bit [2:0]                 ra;
    bit [ecs_pkg::ADDR_W-1:0] target;
    int unsigned              pick;
    int unsigned              n;
    ecs_pkg::opcode_e         op;
    w  = $urandom;
    op = ecs_pkg::opcode_e'($urandom_range(6, 0));
    if (op == ecs_pkg::OP_HALT) op = ecs_pkg::OP_NOOP;
    w[ecs_pkg::OPC_LSB +: ecs_pkg::OPC_W] = op;
    ra = w[ecs_pkg::REGA_LSB +: ecs_pkg::REG_IDX_W];
    n  = written_addrs.size();
    case (op)
      ecs_pkg::OP_LW: begin
        // recent words half the time, to hit store-then-load
        if (n > 8 && $urandom_range(1, 0) == 1) pick = n - 1 - $urandom_range(7, 0);
        else pick = $urandom_range(n - 1, 0);
        target  = written_addrs[pick];
        w[15:0] = target - core_regs[PLAN_CORE][ra][15:0];
      end
      ecs_pkg::OP_BEQ: begin
        if ($urandom_range(2, 0) == 0) w[ecs_pkg::REGB_LSB +: ecs_pkg::REG_IDX_W] = ra;
        if ($urandom_range(3, 0) != 0) w[15:0] = 16'($urandom_range(12, 0)) - 16'd8;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic queue_item(input ecs_pkg::in_t beat);
    ecs_pkg::out_t r;
    r = run_cpu_beat(PLAN_CORE, beat);
    if (beat.kind == ecs_pkg::KIND_LOAD) written_addrs.push_back(beat.load_address);
    if (r.mem_write) written_addrs.push_back(r.mem_address);
    program_beats.push_back(beat);
    beats_queued++;
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned              n;
    bit [ecs_pkg::ADDR_W-1:0] pc;
    n = 0;
    while (n < count) begin
      pc = core_pc[PLAN_CORE];
      if ($urandom_range(99, 0) < 12) begin
        if ($urandom_range(1, 0) == 1) begin
          queue_item(load_item(ecs_pkg::ADDR_W'($urandom), $urandom));
        end else begin
          queue_item(load_item(pc + ecs_pkg::ADDR_W'($urandom_range(4, 1)), $urandom));
        end
        n++;
      end else begin
        if (!fetch_ok(pc) || $urandom_range(99, 0) < 40) begin
          queue_item(load_item(pc, make_instr()));
          n++;
        end
        queue_item(step_item());
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    while (effects_seen < beats_queued) @(negedge clk);
  endtask

  task automatic check_result(input ecs_pkg::out_t got);
    ecs_pkg::out_t want;
    string         diffs;
    effects_seen++;
    if (predicted_effects.size() == 0) begin
      effect_mismatches++;
      if (effect_mismatches <= MAX_REPORTS)
        $display("result beat with nothing predicted: %s", show_result(got));
    end else begin
      want  = predicted_effects.pop_front();
      diffs = "";
      if (got.pc_now         !== want.pc_now)         diffs = {diffs, " pc_now"};
      if (got.halted         !== want.halted)         diffs = {diffs, " halted"};
      if (got.opcode_done    !== want.opcode_done)    diffs = {diffs, " opcode_done"};
      if (got.reg_write      !== want.reg_write)      diffs = {diffs, " reg_write"};
      if (got.reg_index      !== want.reg_index)      diffs = {diffs, " reg_index"};
      if (got.reg_value      !== want.reg_value)      diffs = {diffs, " reg_value"};
      if (got.mem_write      !== want.mem_write)      diffs = {diffs, " mem_write"};
      if (got.mem_address    !== want.mem_address)    diffs = {diffs, " mem_address"};
      if (got.mem_value      !== want.mem_value)      diffs = {diffs, " mem_value"};
      if (got.executed_count !== want.executed_count) diffs = {diffs, " executed_count"};
      if (diffs != "") begin
        effect_mismatches++;
        if (effect_mismatches <= MAX_REPORTS) begin
          $display("result beat %0d mismatch in%s", effects_seen, diffs);
          $display("  expected %s", show_result(want));
          $display("  actual   %s", show_result(got));
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // input driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) predicted_effects.push_back(run_cpu_beat(CHECK_CORE, in_data));
      if (!in_valid || !in_stall) begin
        if (program_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= program_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off counter
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (holds_seen != hold_requests) begin
      holds_seen <= hold_requests;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      out_stall <= (hold_left != 0) || ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: wraps, link past the top of memory, r0 writes, every opcode but halt
    queue_item(load_item(16'h0000, encode(ecs_pkg::OP_NOR, 3'd0, 3'd0, 16'd1)));
    queue_item(step_item());
    queue_item(load_item(16'h0001, encode(ecs_pkg::OP_ADD, 3'd1, 3'd1, 16'd0)));
    queue_item(step_item());
    queue_item(load_item(16'h0002, encode(ecs_pkg::OP_JALR, 3'd1, 3'd2, 16'd0)));
    queue_item(step_item());
    queue_item(load_item(16'hFFFF, encode(ecs_pkg::OP_JALR, 3'd3, 3'd3, 16'd0)));
    queue_item(step_item());
    queue_item(load_item(16'h0000, encode(ecs_pkg::OP_SW, 3'd1, 3'd0, 16'h0005)));
    queue_item(step_item());
    queue_item(load_item(16'h0001, encode(ecs_pkg::OP_LW, 3'd2, 3'd4, 16'h0001)));
    queue_item(step_item());
    queue_item(load_item(16'h0002, encode(ecs_pkg::OP_BEQ, 3'd0, 3'd4, 16'hFFFD)));
    queue_item(step_item());
    queue_item(load_item(16'h0000, 32'hFFFF_FFFF));
    queue_item(step_item());
    queue_item(load_item(16'h0001, encode(ecs_pkg::OP_BEQ, 3'd0, 3'd1, 16'h8000)));
    queue_item(step_item());
    queue_item(load_item(16'h0002, 32'h8000_0000));
    queue_item(step_item());
    queue_item(load_item(16'h1234, 32'h7FFF_FFFF));
    queue_item(load_item(16'h0003, 32'h0000_0000));
    queue_item(step_item());
    random_items(PHASE_BEATS);
    wait_drained();

    send_idle_pct  = 62;
    recv_stall_pct = 0;
    random_items(PHASE_BEATS);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 62;
    random_items(PHASE_BEATS);
    wait_drained();

    send_idle_pct  = 33;
    recv_stall_pct = 33;
    random_items(PHASE_BEATS);
    wait_drained();

    // long output hold-off while input keeps coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = hold_requests + 1;
    random_items(HOLD_BEATS);
    wait_drained();

    // halt, then steps and loads after it
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    queue_item(load_item(core_pc[PLAN_CORE],
                         encode(ecs_pkg::OP_HALT, 3'd7, 3'd7, 16'hFFFF)));
    queue_item(step_item());
    repeat (3) queue_item(step_item());
    repeat (3) queue_item(load_item(ecs_pkg::ADDR_W'($urandom), $urandom));
    repeat (2) queue_item(step_item());
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (effect_mismatches == 0 && predicted_effects.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/ecs_pkg.sv
src/ecs_ram.sv
src/ecs_regfile.sv
src/ecs_alu.sv
src/eight_op_cpu_step_unit.sv
src/ecs_checker.sv
bench/tb.sv
